@@ hdl/tkfv_pkg.sv @@
package tkfv_pkg;

  localparam int VAL_W = 32;
  localparam int CNT_W = 32;
  localparam int TOP_W = 5;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_of_set;
  } tkfv_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    logic [CNT_W-1:0]        frequency;
    logic                    last_result;
    logic                    table_overflowed;
  } tkfv_out_t;

  // counting token, walks the cell row one cell per cycle
  typedef struct packed {
    logic             live;
    logic             last;
    logic             done;
    logic             fresh;
    logic [VAL_W-1:0] val;
  } cnt_tok_t;

  // selection token, carries the best unpicked entry seen so far
  typedef struct packed {
    logic             live;
    logic             have;
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] val;
  } scan_tok_t;

  // broadcast of the entry just emitted
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] val;
  } pick_t;

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_DRAIN,
    ST_SCAN
  } tkfv_state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

  // higher count first, equal counts by larger signed value
  function automatic logic ranks_above(input logic [CNT_W-1:0] ca, input logic [VAL_W-1:0] va,
                                       input logic [CNT_W-1:0] cb, input logic [VAL_W-1:0] vb);
    logic r;
    if (ca != cb) begin
      r = ca > cb;
    end else begin
      r = (va ^ SIGN_FLIP) > (vb ^ SIGN_FLIP);
    end
    return r;
  endfunction

endpackage

@@ hdl/tkfv_cell.sv @@
module tkfv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  tkfv_pkg::pick_t    pick,
  input  tkfv_pkg::cnt_tok_t cnt_in,
  output tkfv_pkg::cnt_tok_t cnt_out,
  input  tkfv_pkg::scan_tok_t scan_in,
  output tkfv_pkg::scan_tok_t scan_out
);
  import tkfv_pkg::*;

  logic             valid_r, valid_nxt;
  logic             picked_r, picked_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cnt_tok_t         cnt_out_r, cnt_out_nxt;
  scan_tok_t        scan_out_r, scan_out_nxt;

  always_comb begin
    valid_nxt    = valid_r;
    picked_nxt   = picked_r;
    val_nxt      = val_r;
    cnt_nxt      = cnt_r;
    cnt_out_nxt  = cnt_in;
    scan_out_nxt = scan_in;

    // count or claim
    if (cnt_in.live && !cnt_in.done) begin
      if (valid_r && val_r == cnt_in.val) begin
        if (cnt_r != CNT_MAX) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        cnt_out_nxt.done = 1'b1;
      end else if (!valid_r) begin
        valid_nxt         = 1'b1;
        val_nxt           = cnt_in.val;
        cnt_nxt           = {{(CNT_W-1){1'b0}}, 1'b1};
        cnt_out_nxt.done  = 1'b1;
        cnt_out_nxt.fresh = 1'b1;
      end
    end

    // selection
    if (scan_in.live && valid_r && !picked_r &&
        (!scan_in.have || ranks_above(cnt_r, val_r, scan_in.cnt, scan_in.val))) begin
      scan_out_nxt.have = 1'b1;
      scan_out_nxt.cnt  = cnt_r;
      scan_out_nxt.val  = val_r;
    end

    if (pick.valid && valid_r && val_r == pick.val) begin
      picked_nxt = 1'b1;
    end

    if (clear) begin
      valid_nxt  = 1'b0;
      picked_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      picked_r   <= 1'b0;
      cnt_out_r  <= '0;
      scan_out_r <= '0;
    end else begin
      valid_r    <= valid_nxt;
      picked_r   <= picked_nxt;
      cnt_out_r  <= cnt_out_nxt;
      scan_out_r <= scan_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
  end

  assign cnt_out  = cnt_out_r;
  assign scan_out = scan_out_r;

endmodule

@@ hdl/top_k_frequent_values.sv @@
// top-k frequency counter. while busy is low one value is taken per cycle (start high and busy
// low) and sent down a row of TABLE_ENTRIES cells, one cell per cycle; the matching cell counts
// it, or the first empty cell takes it. the item flagged last_of_set raises busy until its token
// leaves the row. then each result costs one selection pass down the same row and appears on
// out_data for exactly one cycle with out_valid high. the receiver cannot stall: results must be
// taken as they come. after the last result the table clears in the same cycle and busy drops.
// cfg_ready is always high; write top_count only while busy is low and no token is in the row.
module top_k_frequent_values #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_TOP       = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tkfv_pkg::tkfv_in_t          in_data,
  output logic                        out_valid,
  output tkfv_pkg::tkfv_out_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tkfv_pkg::TOP_W-1:0]  cfg_data
);
  import tkfv_pkg::*;

  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW = $clog2(MAX_TOP + 1);

  tkfv_state_t state_r, state_nxt;
  logic [TOP_W-1:0] top_count_r;
  logic [UW-1:0]    used_r, used_nxt;
  logic             ovf_r, ovf_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [KW-1:0]    want;
  cnt_tok_t         cnt0_r, cnt0_nxt;
  scan_tok_t        scan0_r, scan0_nxt;
  logic             clear;
  pick_t            pick;

  cnt_tok_t  cnt_link  [0:TABLE_ENTRIES];
  scan_tok_t scan_link [0:TABLE_ENTRIES];

  assign cnt_link[0]  = cnt0_r;
  assign scan_link[0] = scan0_r;

  // the cell row
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    tkfv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (clear),
      .pick     (pick),
      .cnt_in   (cnt_link[i]),
      .cnt_out  (cnt_link[i+1]),
      .scan_in  (scan_link[i]),
      .scan_out (scan_link[i+1])
    );
  end

  // results per set: least of top_count (zero reads as one), MAX_TOP and entries held
  always_comb begin
    logic [31:0] w;
    w = (top_count_r == '0) ? 32'd1 : {{(32-TOP_W){1'b0}}, top_count_r};
    if (w > MAX_TOP) begin
      w = MAX_TOP;
    end
    if (w > {{(32-UW){1'b0}}, used_r}) begin
      w = {{(32-UW){1'b0}}, used_r};
    end
    want = w[KW-1:0];
  end

  assign busy      = (state_r != ST_COUNT);
  assign cfg_ready = 1'b1;

  always_comb begin
    cnt_tok_t  cnt_end;
    scan_tok_t scan_end;
    cnt_end  = cnt_link[TABLE_ENTRIES];
    scan_end = scan_link[TABLE_ENTRIES];

    state_nxt = state_r;
    used_nxt  = used_r;
    ovf_nxt   = ovf_r;
    k_nxt     = k_r;
    clear     = 1'b0;
    pick      = '0;
    out_valid = 1'b0;

    out_data.element          = scan_end.val;
    out_data.frequency        = scan_end.cnt;
    out_data.last_result      = ({1'b0, k_r} + 1'b1) == {1'b0, want};
    out_data.table_overflowed = ovf_r;

    cnt0_nxt       = '0;
    cnt0_nxt.live  = start && !busy;
    cnt0_nxt.last  = in_data.last_of_set;
    cnt0_nxt.val   = in_data.value;
    scan0_nxt      = '0;

    // token leaving the row: a new value that found no room, or one that took a cell
    if (cnt_end.live) begin
      if (!cnt_end.done) begin
        ovf_nxt = 1'b1;
      end
      if (cnt_end.fresh) begin
        used_nxt = used_r + 1'b1;
      end
    end

    case (state_r)
      ST_COUNT: begin
        if (start && in_data.last_of_set) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cnt_end.live && cnt_end.last) begin
          state_nxt      = ST_SCAN;
          k_nxt          = '0;
          scan0_nxt.live = 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_end.live) begin
          out_valid = 1'b1;
          pick.valid = 1'b1;
          pick.val   = scan_end.val;
          if (out_data.last_result) begin
            clear     = 1'b1;
            used_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_COUNT;
          end else begin
            k_nxt          = k_r + 1'b1;
            scan0_nxt.live = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      top_count_r <= {{(TOP_W-1){1'b0}}, 1'b1};
      used_r      <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      cnt0_r      <= '0;
      scan0_r     <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      ovf_r   <= ovf_nxt;
      k_r     <= k_nxt;
      cnt0_r  <= cnt0_nxt;
      scan0_r <= scan0_nxt;
      // register transfer on the config channel
      if (cfg_valid && cfg_ready) begin
        top_count_r <= cfg_data;
      end
    end
  end

endmodule
